@@ sv/rrss_pkg.sv @@
// Shared types and constants for the round-robin slot scheduler.
`timescale 1ns / 1ps

package rrss_pkg;

    localparam int ID_W      = 8;
    localparam int FLD_W     = 16;
    localparam int STAT_W    = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int CFG_W     = 32;
    localparam int PADDR_W   = 3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_LEN = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SLOT     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_PAST     = 3'd4;

    // Request kinds carried on s_tuser
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register index of horizon_slots (paddr[2])
    localparam logic REG_HORIZON = 1'b0;
    localparam logic [FLD_W-1:0] HORIZON_RST = 16'd99;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sorted;
    } cell_ctl_t;

endpackage

@@ sv/rrss_cell.sv @@
// One queue slot of the scheduler's cell row: holds an entry and shifts it to a neighbor.
`timescale 1ns / 1ps

module rrss_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = 16,
    parameter int CNT_W     = 8
) (
    input  logic                                    aclk,
    input  rrss_pkg::cell_ctl_t                     ctl,
    input  logic [CNT_W-1:0]                        count,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   new_ent,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   tail_ent,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   left_ent,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   right_ent,
    input  logic                                    left_ge,
    output logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   ent_out,
    output logic                                    ge_out
);

    localparam int ENT_W = rrss_pkg::ID_W + 2 * TIME_BITS;

    logic [ENT_W-1:0]     ent_reg;
    logic [ENT_W-1:0]     ent_next;
    logic [TIME_BITS-1:0] own_start;
    logic [TIME_BITS-1:0] new_start;
    logic                 valid;
    logic                 at_count;
    logic                 is_tail;

    assign own_start = ent_reg[2*TIME_BITS-1:TIME_BITS];
    assign new_start = new_ent[2*TIME_BITS-1:TIME_BITS];
    assign valid     = count > CNT_W'(IDX);
    assign at_count  = count == CNT_W'(IDX);
    assign is_tail   = count == CNT_W'(IDX + 1);

    // Cells at or after the insert point move right; equal starts stay ahead
    assign ge_out = (ctl.sorted && valid && (own_start > new_start)) || at_count;

    always_comb begin
        ent_next = ent_reg;
        case (ctl.op)
            rrss_pkg::CELL_INSERT: begin
                if (left_ge) begin
                    ent_next = left_ent;
                end else if (ge_out) begin
                    ent_next = new_ent;
                end
            end
            rrss_pkg::CELL_ROTATE: begin
                ent_next = is_tail ? tail_ent : right_ent;
            end
            rrss_pkg::CELL_POP: begin
                ent_next = right_ent;
            end
            default: begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent_out = ent_reg;

endmodule

@@ sv/rrss_chain.sv @@
// Row of queue cells wired head to tail, with the head entry brought out.
`timescale 1ns / 1ps

module rrss_chain #(
    parameter int MAX_PROCS = 128,
    parameter int TIME_BITS = 16
) (
    input  logic                                    aclk,
    input  rrss_pkg::cell_ctl_t                     ctl,
    input  logic [$clog2(MAX_PROCS+1)-1:0]          count,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   new_ent,
    input  logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   tail_ent,
    output logic [rrss_pkg::ID_W+2*TIME_BITS-1:0]   head_ent
);

    localparam int ENT_W = rrss_pkg::ID_W + 2 * TIME_BITS;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    logic [ENT_W-1:0] ent   [MAX_PROCS];
    logic             ge    [MAX_PROCS];

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        logic [ENT_W-1:0] left_ent;
        logic [ENT_W-1:0] right_ent;
        logic             left_ge;

        if (i == 0) begin : g_first
            assign left_ent = '0;
            assign left_ge  = 1'b0;
        end else begin : g_mid
            assign left_ent = ent[i-1];
            assign left_ge  = ge[i-1];
        end

        if (i == MAX_PROCS - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = ent[i+1];
        end

        rrss_cell #(
            .IDX       (i),
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count),
            .new_ent   (new_ent),
            .tail_ent  (tail_ent),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .left_ge   (left_ge),
            .ent_out   (ent[i]),
            .ge_out    (ge[i])
        );
    end

    assign head_ent = ent[0];

endmodule

@@ sv/round_robin_slot_scheduler.sv @@
// Top level of the round-robin slot scheduler: request handling, slot control, result register.
`timescale 1ns / 1ps

// Usage:
// s_ channel takes requests: s_tuser is the kind (0 add, 1 tick), s_tdata the
// process id, start slot and length. m_ channel returns one word per request:
// m_tuser is the status, m_tlast marks the final slot of the horizon.
// The APB port holds horizon_slots at address 0; write it only while idle.
// Before the first tick, adds are placed in start order; afterwards at the tail.
// An add or a refused tick is answered in the cycle after acceptance.
// A tick walks the queue from the head, one entry per cycle, rotating each
// entry whose start slot is still ahead to the tail of the cell row; at most
// the queue depth of entries are skipped before the result is registered.
// A new request is taken once the scheduler is idle and the result register is
// empty or being read in the same cycle; a stalled receiver holds the result
// and stalls the end of a tick, so no word is lost.
// Reset empties the queue, clears the slot counter and sets the horizon to 99.

module round_robin_slot_scheduler #(
    parameter int MAX_PROCS = 128,
    parameter int TIME_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: proc_id[7:0], start_time[23:8], exec_time[39:24]
    input  logic [rrss_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[0]
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: slot_index[15:0], busy_res[16], run_id[24:17], finished[25],
    //          turnaround[41:26], zero[47:42]
    output logic [rrss_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: status[2:0]
    output logic [rrss_pkg::STAT_W-1:0]     m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrss_pkg::PADDR_W-1:0]    paddr,
    input  logic [rrss_pkg::CFG_W-1:0]      pwdata,
    output logic [rrss_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);

    localparam int ENT_W  = rrss_pkg::ID_W + 2 * TIME_BITS;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int WIDE_W = (TIME_BITS > rrss_pkg::FLD_W) ? TIME_BITS : rrss_pkg::FLD_W;
    localparam int SUM_W  = WIDE_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            scan_left_reg, scan_left_next;
    logic [TIME_BITS-1:0]        slot_reg, slot_next;
    logic                        started_reg, started_next;
    logic [rrss_pkg::FLD_W-1:0]  horizon_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [rrss_pkg::STAT_W-1:0] status_reg, status_next;
    logic [rrss_pkg::FLD_W-1:0]  slot_idx_reg, slot_idx_next;
    logic                        busy_reg, busy_next;
    logic [rrss_pkg::ID_W-1:0]   run_id_reg, run_id_next;
    logic                        fin_reg, fin_next;
    logic [rrss_pkg::FLD_W-1:0]  turn_reg, turn_next;
    logic                        last_reg, last_next;

    rrss_pkg::cell_ctl_t         ctl;
    logic [ENT_W-1:0]            new_ent;
    logic [ENT_W-1:0]            tail_ent;
    logic [ENT_W-1:0]            head_ent;

    logic [rrss_pkg::ID_W-1:0]   in_id;
    logic [WIDE_W-1:0]           in_start_wide;
    logic [WIDE_W-1:0]           in_exec_wide;
    logic [TIME_BITS-1:0]        in_start;
    logic [TIME_BITS-1:0]        in_exec;
    logic [rrss_pkg::ID_W-1:0]   head_id;
    logic [TIME_BITS-1:0]        head_start;
    logic [TIME_BITS-1:0]        head_remain;
    logic [TIME_BITS-1:0]        head_left;
    logic [WIDE_W-1:0]           slot_wide;
    logic [SUM_W-1:0]            turn_sum;
    logic [SUM_W-1:0]            slot_plus1;

    logic st_idle, st_scan, out_free, accept, is_add, past_horizon;
    logic queue_full, add_ok, head_ready, head_done, scan_empty, scan_fin, scan_rot;
    logic cfg_wr;

    assign st_idle  = state_reg == ST_IDLE;
    assign st_scan  = state_reg == ST_SCAN;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = st_idle && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_add   = s_tuser == rrss_pkg::REQ_ADD;

    assign in_id         = s_tdata[7:0];
    assign in_start_wide = WIDE_W'(s_tdata[23:8]);
    assign in_exec_wide  = WIDE_W'(s_tdata[39:24]);
    assign in_start      = in_start_wide[TIME_BITS-1:0];
    assign in_exec       = in_exec_wide[TIME_BITS-1:0];
    assign new_ent       = {in_id, in_start, in_exec};

    assign head_id     = head_ent[ENT_W-1:2*TIME_BITS];
    assign head_start  = head_ent[2*TIME_BITS-1:TIME_BITS];
    assign head_remain = head_ent[TIME_BITS-1:0];
    assign head_left   = head_remain - TIME_BITS'(1);
    assign head_done   = head_left == '0;
    assign head_ready  = head_start <= slot_reg;

    assign slot_wide    = WIDE_W'(slot_reg);
    assign past_horizon = slot_wide >= WIDE_W'(horizon_reg);
    assign slot_plus1   = SUM_W'(slot_reg) + SUM_W'(1);
    assign turn_sum     = slot_plus1 - SUM_W'(head_start);

    assign queue_full = count_reg == CNT_W'(MAX_PROCS);
    assign add_ok     = accept && is_add && (in_exec != '0) && !queue_full;
    assign scan_empty = scan_left_reg == '0;
    assign scan_fin   = st_scan && (scan_empty || head_ready) && out_free;
    assign scan_rot   = st_scan && !scan_empty && !head_ready;

    // Cell row control: at most one queue move per cycle
    always_comb begin
        ctl.op     = rrss_pkg::CELL_HOLD;
        ctl.sorted = !started_reg;
        tail_ent   = head_ent;
        count_next = count_reg;
        if (add_ok) begin
            ctl.op     = rrss_pkg::CELL_INSERT;
            count_next = count_reg + CNT_W'(1);
        end else if (scan_rot) begin
            ctl.op = rrss_pkg::CELL_ROTATE;
        end else if (scan_fin && !scan_empty) begin
            if (head_done) begin
                ctl.op     = rrss_pkg::CELL_POP;
                count_next = count_reg - CNT_W'(1);
            end else begin
                ctl.op   = rrss_pkg::CELL_ROTATE;
                tail_ent = {head_id, head_start, head_left};
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        scan_left_next = scan_left_reg;
        slot_next      = slot_reg;
        started_next   = started_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_add && !past_horizon) begin
                    state_next     = ST_SCAN;
                    started_next   = 1'b1;
                    scan_left_next = count_reg;
                end
            end
            ST_SCAN: begin
                if (scan_rot) begin
                    scan_left_next = scan_left_reg - CNT_W'(1);
                end else if (scan_fin) begin
                    state_next = ST_IDLE;
                    slot_next  = slot_reg + TIME_BITS'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        slot_idx_next = slot_idx_reg;
        busy_next     = busy_reg;
        run_id_next   = run_id_reg;
        fin_next      = fin_reg;
        turn_next     = turn_reg;
        last_next     = last_reg;
        if (accept && (is_add || past_horizon)) begin
            m_tvalid_next = 1'b1;
            slot_idx_next = '0;
            busy_next     = 1'b0;
            run_id_next   = '0;
            fin_next      = 1'b0;
            turn_next     = '0;
            last_next     = 1'b0;
            if (!is_add) begin
                status_next = rrss_pkg::STAT_PAST;
            end else if (in_exec == '0) begin
                status_next = rrss_pkg::STAT_ZERO_LEN;
            end else if (queue_full) begin
                status_next = rrss_pkg::STAT_FULL;
            end else begin
                status_next = rrss_pkg::STAT_ADDED;
            end
        end else if (scan_fin) begin
            m_tvalid_next = 1'b1;
            status_next   = rrss_pkg::STAT_SLOT;
            slot_idx_next = slot_wide[rrss_pkg::FLD_W-1:0];
            busy_next     = !scan_empty;
            run_id_next   = scan_empty ? '0 : head_id;
            fin_next      = !scan_empty && head_done;
            turn_next     = (!scan_empty && head_done) ? turn_sum[rrss_pkg::FLD_W-1:0] : '0;
            last_next     = slot_plus1 == SUM_W'(horizon_reg);
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_left_reg <= '0;
            slot_reg      <= '0;
            started_reg   <= 1'b0;
            horizon_reg   <= rrss_pkg::HORIZON_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_left_reg <= scan_left_next;
            slot_reg      <= slot_next;
            started_reg   <= started_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr && (paddr[2] == rrss_pkg::REG_HORIZON)) begin
                horizon_reg <= pwdata[rrss_pkg::FLD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        slot_idx_reg <= slot_idx_next;
        busy_reg     <= busy_next;
        run_id_reg   <= run_id_next;
        fin_reg      <= fin_next;
        turn_reg     <= turn_next;
        last_reg     <= last_next;
    end

    rrss_chain #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) u_chain (
        .aclk     (aclk),
        .ctl      (ctl),
        .count    (count_reg),
        .new_ent  (new_ent),
        .tail_ent (tail_ent),
        .head_ent (head_ent)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, turn_reg, fin_reg, run_id_reg, busy_reg, slot_idx_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == rrss_pkg::REG_HORIZON) ?
                      rrss_pkg::CFG_W'(horizon_reg) : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("queue count above capacity");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_scan |-> scan_left_reg <= count_reg)
        else $error("scan counter above queue count");

    a_tick_enters_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_add && !past_horizon) |=> st_scan && started_reg)
        else $error("accepted tick did not start a scan");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1)
             || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count moved by more than one");
`endif

endmodule
